@@ rtl/cqss_pkg.sv @@
// shared types, codes and reset values for the channel quality score select unit
// no dependencies; used by every module under rtl
package cqss_pkg;

  localparam int CH_W        = 7;
  localparam int SCORE_W     = 10;
  localparam int EPOCH_W     = 8;
  localparam int CMD_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int OP_W        = 2;

  localparam int CHANNEL_COUNT_DEF = 128;

  // command codes; the two top codes both mean soft init
  localparam logic [CMD_W-1:0] CMD_SUCCESS     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FAILURE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_CHANNEL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_EPOCH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT_EPOCH  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SELECT      = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANNEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_CHANNEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_START     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_CEILING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_STEP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FAILURE_STEP    = 3'd6;

  // register reset values
  localparam logic [CH_W-1:0]    MIN_CHANNEL_RST     = 7'd0;
  localparam logic [CH_W-1:0]    MAX_CHANNEL_RST     = 7'd127;
  localparam logic [CH_W-1:0]    DEFAULT_CHANNEL_RST = 7'd0;
  localparam logic [SCORE_W-1:0] SCORE_START_RST     = 10'd100;
  localparam logic [SCORE_W-1:0] SCORE_CEILING_RST   = 10'd1000;
  localparam logic [SCORE_W-1:0] SUCCESS_STEP_RST    = 10'd1;
  localparam logic [SCORE_W-1:0] FAILURE_STEP_RST    = 10'd10;

  // what the head cell does to each score passing through
  localparam logic [OP_W-1:0] OP_SUCCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_FAILURE = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT  = 2'd2;
  localparam logic [OP_W-1:0] OP_INIT    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CH_W-1:0]    channel;
    logic [EPOCH_W-1:0] epoch_value;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0]    cur_channel;
    logic [EPOCH_W-1:0] epoch;
    logic [CH_W-1:0]    best_channel;
    logic               accepted;
  } result_t;

  typedef struct packed {
    logic [CH_W-1:0]    min_channel;
    logic [CH_W-1:0]    max_channel;
    logic [CH_W-1:0]    default_channel;
    logic [SCORE_W-1:0] score_start;
    logic [SCORE_W-1:0] score_ceiling;
    logic [SCORE_W-1:0] success_step;
    logic [SCORE_W-1:0] failure_step;
  } cfg_t;

  // control from the sequencer to the head cell
  typedef struct packed {
    logic            shift;
    logic            first;
    logic [OP_W-1:0] op;
    logic [CH_W-1:0] channel;
    logic [CH_W-1:0] active;
    logic [CH_W-1:0] pos;
  } scan_ctrl_t;

endpackage

@@ rtl/channel_quality_score_select_unit.sv @@
// top level of the channel quality score select unit: sequencer, registers, score ring
// depends on cqss_pkg, cqss_cell and cqss_head
//
// flow: success, failure, select and soft init go from idle through the scan state for one full
//   turn of the score ring through the head cell, then the done state and the registered result
//   strobe; set channel, set epoch, next epoch and an ignored success or failure skip the scan
// a new command is taken only while the unit is idle (busy low), never while one is in flight
// reset: scores 100, current channel 0, epoch 0, registers to defaults, no clearing pass
// results are a one-cycle strobe; the receiver cannot stall
module channel_quality_score_select_unit #(
  parameter int CHANNEL_COUNT = cqss_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  cqss_pkg::cmd_t                  cmd_i,
  output logic                            result_valid_o,
  output cqss_pkg::result_t               result_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cqss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cqss_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(CHANNEL_COUNT - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [IDX_W-1:0]                pos_q, pos_d;
  logic [cqss_pkg::OP_W-1:0]       op_q, op_d;
  logic [cqss_pkg::CH_W-1:0]       ch_q, ch_d;
  logic                            acc_q, acc_d;
  logic                            sel_q, sel_d;
  logic [cqss_pkg::CH_W-1:0]       active_q, active_d;
  logic [cqss_pkg::EPOCH_W-1:0]    epoch_q, epoch_d;
  logic                            result_valid_q, result_valid_d;
  cqss_pkg::result_t               result_q, result_d;
  cqss_pkg::cfg_t                  cfg_q;

  logic                            accept;
  logic                            chan_ok;
  cqss_pkg::scan_ctrl_t            ctrl;
  logic [cqss_pkg::SCORE_W-1:0]    ring_score [CHANNEL_COUNT];
  logic [cqss_pkg::SCORE_W-1:0]    head_score;
  logic [cqss_pkg::CH_W-1:0]       head_best;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // channel check against the configured window and the table size
  assign chan_ok = (cmd_i.channel >= cfg_q.min_channel) &&
                   (cmd_i.channel <= cfg_q.max_channel) &&
                   ({1'b0, cmd_i.channel} < 8'(CHANNEL_COUNT));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_channel     <= cqss_pkg::MIN_CHANNEL_RST;
      cfg_q.max_channel     <= cqss_pkg::MAX_CHANNEL_RST;
      cfg_q.default_channel <= cqss_pkg::DEFAULT_CHANNEL_RST;
      cfg_q.score_start     <= cqss_pkg::SCORE_START_RST;
      cfg_q.score_ceiling   <= cqss_pkg::SCORE_CEILING_RST;
      cfg_q.success_step    <= cqss_pkg::SUCCESS_STEP_RST;
      cfg_q.failure_step    <= cqss_pkg::FAILURE_STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cqss_pkg::REG_MIN_CHANNEL:     cfg_q.min_channel     <= cfg_data_i[cqss_pkg::CH_W-1:0];
        cqss_pkg::REG_MAX_CHANNEL:     cfg_q.max_channel     <= cfg_data_i[cqss_pkg::CH_W-1:0];
        cqss_pkg::REG_DEFAULT_CHANNEL: begin
          cfg_q.default_channel <= cfg_data_i[cqss_pkg::CH_W-1:0];
        end
        cqss_pkg::REG_SCORE_START:     cfg_q.score_start     <= cfg_data_i;
        cqss_pkg::REG_SCORE_CEILING:   cfg_q.score_ceiling   <= cfg_data_i;
        cqss_pkg::REG_SUCCESS_STEP:    cfg_q.success_step    <= cfg_data_i;
        cqss_pkg::REG_FAILURE_STEP:    cfg_q.failure_step    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // command sequencer
  always_comb begin
    state_d        = state_q;
    pos_d          = pos_q;
    op_d           = op_q;
    ch_d           = ch_q;
    acc_d          = acc_q;
    sel_d          = sel_q;
    active_d       = active_q;
    epoch_d        = epoch_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ch_d    = cmd_i.channel;
          acc_d   = 1'b1;
          sel_d   = 1'b0;
          state_d = S_DONE;
          case (cmd_i.cmd)
            cqss_pkg::CMD_SUCCESS, cqss_pkg::CMD_FAILURE: begin
              // invalid channel: ignored, no turn of the ring
              acc_d = chan_ok;
              op_d  = (cmd_i.cmd == cqss_pkg::CMD_SUCCESS) ? cqss_pkg::OP_SUCCESS
                                                           : cqss_pkg::OP_FAILURE;
              if (chan_ok) begin
                state_d = S_SCAN;
              end
            end
            cqss_pkg::CMD_SET_CHANNEL: begin
              acc_d = chan_ok;
              if (chan_ok) begin
                active_d = cmd_i.channel;
              end
            end
            cqss_pkg::CMD_SET_EPOCH: begin
              epoch_d = cmd_i.epoch_value;
            end
            cqss_pkg::CMD_NEXT_EPOCH: begin
              epoch_d = epoch_q + 8'd1;
            end
            cqss_pkg::CMD_SELECT: begin
              op_d    = cqss_pkg::OP_SELECT;
              sel_d   = 1'b1;
              state_d = S_SCAN;
            end
            default: begin
              // soft init: every score rewritten on its way past the head
              active_d = cfg_q.default_channel;
              epoch_d  = '0;
              op_d     = cqss_pkg::OP_INIT;
              state_d  = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (pos_q == LAST_POS) begin
          pos_d   = '0;
          state_d = S_DONE;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_DONE: begin
        result_valid_d           = 1'b1;
        result_d.cur_channel     = active_q;
        result_d.epoch           = epoch_q;
        result_d.best_channel    = sel_q ? head_best : '0;
        result_d.accepted        = acc_q;
        state_d                  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      pos_q          <= '0;
      active_q       <= cqss_pkg::DEFAULT_CHANNEL_RST;
      epoch_q        <= '0;
      result_valid_q <= 1'b0;
      op_q           <= cqss_pkg::OP_SELECT;
    end else begin
      state_q        <= state_d;
      pos_q          <= pos_d;
      active_q       <= active_d;
      epoch_q        <= epoch_d;
      result_valid_q <= result_valid_d;
      op_q           <= op_d;
    end
  end

  // beat payload and per-command scratch
  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    acc_q    <= acc_d;
    sel_q    <= sel_d;
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // score ring: cell 0 feeds the head, the head feeds the last cell,
  // so cell 0 always holds channel pos_q during a turn
  assign ctrl.shift   = (state_q == S_SCAN);
  assign ctrl.first   = (pos_q == '0);
  assign ctrl.op      = op_q;
  assign ctrl.channel = ch_q;
  assign ctrl.active  = active_q;
  assign ctrl.pos     = cqss_pkg::CH_W'(pos_q);

  cqss_head u_head (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .score_i (ring_score[0]),
    .score_o (head_score),
    .best_o  (head_best)
  );

  for (genvar k = 0; k < CHANNEL_COUNT; k++) begin : g_cell
    logic [cqss_pkg::SCORE_W-1:0] cell_in;
    if (k == CHANNEL_COUNT - 1) begin : g_tail
      assign cell_in = head_score;
    end else begin : g_mid
      assign cell_in = ring_score[k+1];
    end
    cqss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctrl.shift),
      .score_i (cell_in),
      .score_o (ring_score[k])
    );
  end

  // ring position rests at zero between turns so the ring stays aligned
  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> pos_q == '0)
    else $error("ring position not aligned while idle");

  // a result beat only follows the done state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == S_DONE)
    else $error("result beat without a finished command");

  // an accepted command always makes the unit busy
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command accepted but unit not busy");

  // an ignored command never reports a best channel
  a_rejected_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.accepted |-> result_o.best_channel == '0)
    else $error("ignored command reports a best channel");

endmodule

@@ rtl/cqss_cell.sv @@
// one score cell of the rotating score ring
// depends on cqss_pkg
module cqss_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [cqss_pkg::SCORE_W-1:0] score_i,
  output logic [cqss_pkg::SCORE_W-1:0] score_o
);

  logic [cqss_pkg::SCORE_W-1:0] score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= cqss_pkg::SCORE_START_RST;
    end else if (shift_i) begin
      score_q <= score_i;
    end
  end

  assign score_o = score_q;

endmodule

@@ rtl/cqss_head.sv @@
// head cell: updates the score leaving the ring and tracks the best scorer
// depends on cqss_pkg
module cqss_head (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cqss_pkg::scan_ctrl_t         ctrl_i,
  input  cqss_pkg::cfg_t               cfg_i,
  input  logic [cqss_pkg::SCORE_W-1:0] score_i,
  output logic [cqss_pkg::SCORE_W-1:0] score_o,
  output logic [cqss_pkg::CH_W-1:0]    best_o
);

  logic [cqss_pkg::SCORE_W:0]   sum;
  logic [cqss_pkg::SCORE_W-1:0] diff;
  logic [cqss_pkg::SCORE_W-1:0] inc_score;
  logic [cqss_pkg::SCORE_W-1:0] dec_score;
  logic                         hit;

  logic [cqss_pkg::SCORE_W-1:0] max_q, max_d;
  logic [cqss_pkg::CH_W-1:0]    max_idx_q, max_idx_d;
  logic [cqss_pkg::SCORE_W-1:0] act_score_q, act_score_d;
  logic                         act_seen_q, act_seen_d;

  assign hit  = (ctrl_i.pos == ctrl_i.channel);
  assign sum  = {1'b0, score_i} + {1'b0, cfg_i.success_step};
  assign diff = score_i - cfg_i.failure_step;

  // clamp to zero and the ceiling
  always_comb begin
    if (sum > {1'b0, cfg_i.score_ceiling}) begin
      inc_score = cfg_i.score_ceiling;
    end else begin
      inc_score = sum[cqss_pkg::SCORE_W-1:0];
    end
    if (score_i < cfg_i.failure_step) begin
      dec_score = '0;
    end else if (diff > cfg_i.score_ceiling) begin
      dec_score = cfg_i.score_ceiling;
    end else begin
      dec_score = diff;
    end
  end

  always_comb begin
    case (ctrl_i.op)
      cqss_pkg::OP_SUCCESS: score_o = hit ? inc_score : score_i;
      cqss_pkg::OP_FAILURE: score_o = hit ? dec_score : score_i;
      cqss_pkg::OP_INIT:    score_o = cfg_i.score_start;
      default:              score_o = score_i;
    endcase
  end

  // running maximum, lowest index first, plus the current channel's score
  always_comb begin
    max_d       = max_q;
    max_idx_d   = max_idx_q;
    act_score_d = act_score_q;
    act_seen_d  = act_seen_q;
    if (ctrl_i.shift && ctrl_i.op == cqss_pkg::OP_SELECT) begin
      if (ctrl_i.first || score_i > max_q) begin
        max_d     = score_i;
        max_idx_d = ctrl_i.pos;
      end
      if (ctrl_i.pos == ctrl_i.active) begin
        act_score_d = score_i;
        act_seen_d  = 1'b1;
      end else if (ctrl_i.first) begin
        act_seen_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_seen_q <= 1'b0;
    end else begin
      act_seen_q <= act_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q       <= max_d;
    max_idx_q   <= max_idx_d;
    act_score_q <= act_score_d;
  end

  // current channel wins a tie with the maximum
  assign best_o = (act_seen_q && act_score_q == max_q) ? ctrl_i.active : max_idx_q;

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the channel quality score select unit
// depends on cqss_pkg and channel_quality_score_select_unit from rtl, which in turn needs cqss_cell and cqss_head
// directed table first, then random command phases under several register settings
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_COUNT       = cqss_pkg::CHANNEL_COUNT_DEF;
  localparam int ITEMS_PER_PASS = 234;
  localparam int PASS_COUNT     = 6;
  localparam int CYCLE_LIMIT    = 1_600_000;
  localparam int MAX_REPORTS    = 10;

  // the two top command codes both mean soft init; the package names only the first six
  localparam logic [cqss_pkg::CMD_W-1:0] CMD_INIT_LO = 3'd6;
  localparam logic [cqss_pkg::CMD_W-1:0] CMD_INIT_HI = 3'd7;

  // one row of the directed table: either a register write or a command
  typedef struct {
    bit                              is_reg;
    bit                              typed;
    cqss_pkg::cmd_t                  c;
    cqss_pkg::result_t               want;
    logic [cqss_pkg::CFG_IDX_W-1:0]  idx;
    logic [cqss_pkg::CFG_DATA_W-1:0] data;
  } plan_row_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            start       = 1'b0;
  logic                            busy;
  cqss_pkg::cmd_t                  cmd_i       = '0;
  logic                            result_valid_o;
  cqss_pkg::result_t               result_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [cqss_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [cqss_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // shadow of the block: register copy, score table, current channel, epoch
  cqss_pkg::cfg_t                  shadow_cfg;
  logic [cqss_pkg::SCORE_W-1:0]    score_tab [CH_COUNT];
  logic [cqss_pkg::CH_W-1:0]       active_ch;
  logic [cqss_pkg::EPOCH_W-1:0]    epoch_cnt;

  cqss_pkg::result_t               pending_results [$];
  plan_row_t                       plan [$];
  int                              sender_idle_pct = 0;
  int                              error_cnt       = 0;
  int                              cycle_cnt       = 0;

  channel_quality_score_select_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // run limit; a hung handshake ends here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // shadow model
  // ---------------------------------------------------------------------------------------

  function automatic bit channel_valid(logic [cqss_pkg::CH_W-1:0] ch);
    return ch >= shadow_cfg.min_channel && ch <= shadow_cfg.max_channel &&
           int'(ch) < CH_COUNT;
  endfunction

  // bump one score by a signed amount, pinned to zero and the ceiling
  function automatic logic [cqss_pkg::SCORE_W-1:0] clamped_score(
      logic [cqss_pkg::SCORE_W-1:0] s, int delta);
    int v;
    v = int'(s) + delta;
    if (v < 0) return '0;
    if (v > int'(shadow_cfg.score_ceiling)) return shadow_cfg.score_ceiling;
    return v[cqss_pkg::SCORE_W-1:0];
  endfunction

  function automatic void shadow_soft_init();
    for (int i = 0; i < CH_COUNT; i++) score_tab[i] = shadow_cfg.score_start;
    active_ch = shadow_cfg.default_channel;
    epoch_cnt = '0;
  endfunction

  // apply one command to the shadow and return the result it must produce
  function automatic cqss_pkg::result_t apply_channel_cmd(cqss_pkg::cmd_t c);
    cqss_pkg::result_t            r;
    logic [cqss_pkg::SCORE_W-1:0] top;
    r = '0;
    r.accepted = 1'b1;
    case (c.cmd)
      cqss_pkg::CMD_SUCCESS, cqss_pkg::CMD_FAILURE, cqss_pkg::CMD_SET_CHANNEL: begin
        if (!channel_valid(c.channel)) begin
          // invalid channel: nothing changes, only the flag drops
          r.accepted = 1'b0;
        end else if (c.cmd == cqss_pkg::CMD_SUCCESS) begin
          score_tab[c.channel] = clamped_score(score_tab[c.channel],
                                               int'(shadow_cfg.success_step));
        end else if (c.cmd == cqss_pkg::CMD_FAILURE) begin
          score_tab[c.channel] = clamped_score(score_tab[c.channel],
                                               -int'(shadow_cfg.failure_step));
        end else begin
          active_ch = c.channel;
        end
      end
      cqss_pkg::CMD_SET_EPOCH:  epoch_cnt = c.epoch_value;
      cqss_pkg::CMD_NEXT_EPOCH: epoch_cnt = epoch_cnt + 1'b1;
      cqss_pkg::CMD_SELECT: begin
        // current channel holds ties; only a strictly higher score takes over,
        // scanning upward so the lowest index wins among the rest
        r.best_channel = active_ch;
        top = score_tab[active_ch];
        for (int i = 0; i < CH_COUNT; i++) begin
          if (score_tab[i] > top) begin
            top = score_tab[i];
            r.best_channel = i[cqss_pkg::CH_W-1:0];
          end
        end
      end
      default: shadow_soft_init();
    endcase
    r.cur_channel = active_ch;
    r.epoch = epoch_cnt;
    return r;
  endfunction

  function automatic void shadow_write_reg(logic [cqss_pkg::CFG_IDX_W-1:0] idx,
                                           logic [cqss_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      cqss_pkg::REG_MIN_CHANNEL:     shadow_cfg.min_channel     = d[cqss_pkg::CH_W-1:0];
      cqss_pkg::REG_MAX_CHANNEL:     shadow_cfg.max_channel     = d[cqss_pkg::CH_W-1:0];
      cqss_pkg::REG_DEFAULT_CHANNEL: shadow_cfg.default_channel = d[cqss_pkg::CH_W-1:0];
      cqss_pkg::REG_SCORE_START:     shadow_cfg.score_start     = d;
      cqss_pkg::REG_SCORE_CEILING:   shadow_cfg.score_ceiling   = d;
      cqss_pkg::REG_SUCCESS_STEP:    shadow_cfg.success_step    = d;
      cqss_pkg::REG_FAILURE_STEP:    shadow_cfg.failure_step    = d;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // result checker: every strobe is matched against the oldest expectation
  // ---------------------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    cqss_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        error_cnt++;
        if (error_cnt <= MAX_REPORTS)
          $display("unexpected result beat: cur %0d epoch %0d best %0d acc %0d",
                   result_o.cur_channel, result_o.epoch, result_o.best_channel,
                   result_o.accepted);
      end else begin
        want = pending_results.pop_front();
        if (result_o.cur_channel !== want.cur_channel || result_o.epoch !== want.epoch ||
            result_o.best_channel !== want.best_channel ||
            result_o.accepted !== want.accepted)
        begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display({"result mismatch (exp/got): cur %0d/%0d epoch %0d/%0d ",
                      "best %0d/%0d acc %0d/%0d"},
                     want.cur_channel, result_o.cur_channel, want.epoch, result_o.epoch,
                     want.best_channel, result_o.best_channel, want.accepted,
                     result_o.accepted);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------------------

  // present one command and hold it until a beat goes through; start stays high
  // after the accepting edge so a back-to-back command needs no second assignment
  task automatic send_cmd(cqss_pkg::cmd_t c, bit typed, cqss_pkg::result_t typed_res);
    cqss_pkg::result_t predicted;
    // sender idles cycle by cycle with the phase's probability
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    predicted = apply_channel_cmd(c);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // registers are only touched once every result is back
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [cqss_pkg::CFG_IDX_W-1:0] idx,
                           logic [cqss_pkg::CFG_DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_write_reg(idx, d);
  endtask

  task automatic load_settings(int mn, int mx, int dflt, int st, int ceil, int up, int down);
    drain();
    write_reg(cqss_pkg::REG_MIN_CHANNEL, cqss_pkg::CFG_DATA_W'(mn));
    write_reg(cqss_pkg::REG_MAX_CHANNEL, cqss_pkg::CFG_DATA_W'(mx));
    write_reg(cqss_pkg::REG_DEFAULT_CHANNEL, cqss_pkg::CFG_DATA_W'(dflt));
    write_reg(cqss_pkg::REG_SCORE_START, cqss_pkg::CFG_DATA_W'(st));
    write_reg(cqss_pkg::REG_SCORE_CEILING, cqss_pkg::CFG_DATA_W'(ceil));
    write_reg(cqss_pkg::REG_SUCCESS_STEP, cqss_pkg::CFG_DATA_W'(up));
    write_reg(cqss_pkg::REG_FAILURE_STEP, cqss_pkg::CFG_DATA_W'(down));
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // directed table builders
  // ---------------------------------------------------------------------------------------

  function automatic void plan_cmd(logic [cqss_pkg::CMD_W-1:0] op, int ch, int ev);
    plan_row_t row;
    row = '{default: '0};
    row.c.cmd = op;
    row.c.channel = cqss_pkg::CH_W'(ch);
    row.c.epoch_value = cqss_pkg::EPOCH_W'(ev);
    plan.push_back(row);
  endfunction

  // command whose result is plain from the spec, typed in by hand
  function automatic void plan_typed(logic [cqss_pkg::CMD_W-1:0] op, int ch, int ev,
                                     int cur, int ep, int best, bit acc);
    plan_cmd(op, ch, ev);
    plan[$].typed = 1'b1;
    plan[$].want.cur_channel = cqss_pkg::CH_W'(cur);
    plan[$].want.epoch = cqss_pkg::EPOCH_W'(ep);
    plan[$].want.best_channel = cqss_pkg::CH_W'(best);
    plan[$].want.accepted = acc;
  endfunction

  function automatic void plan_reg(logic [cqss_pkg::CFG_IDX_W-1:0] idx, int d);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.idx = idx;
    row.data = cqss_pkg::CFG_DATA_W'(d);
    plan.push_back(row);
  endfunction

  // channel picker: mostly inside the valid window, often on a few hot channels so
  // scores drift apart and selects have a real winner; the rest anywhere
  function automatic logic [cqss_pkg::CH_W-1:0] pick_channel();
    int lo, hi, span;
    lo = shadow_cfg.min_channel;
    hi = shadow_cfg.max_channel;
    if (lo <= hi && $urandom_range(0, 3) != 0) begin
      span = hi - lo;
      if ($urandom_range(0, 1) == 1)
        return cqss_pkg::CH_W'(lo + int'($urandom_range(0, span < 5 ? span : 5)));
      return cqss_pkg::CH_W'(lo + int'($urandom_range(0, span)));
    end
    return cqss_pkg::CH_W'($urandom_range(0, CH_COUNT - 1));
  endfunction

  function automatic cqss_pkg::cmd_t random_cmd();
    cqss_pkg::cmd_t c;
    int             r;
    r = $urandom_range(0, 99);
    c.channel = pick_channel();
    c.epoch_value = cqss_pkg::EPOCH_W'($urandom_range(0, 255));
    if (r < 30)      c.cmd = cqss_pkg::CMD_SUCCESS;
    else if (r < 55) c.cmd = cqss_pkg::CMD_FAILURE;
    else if (r < 66) c.cmd = cqss_pkg::CMD_SET_CHANNEL;
    else if (r < 71) c.cmd = cqss_pkg::CMD_SET_EPOCH;
    else if (r < 78) c.cmd = cqss_pkg::CMD_NEXT_EPOCH;
    else if (r < 96) c.cmd = cqss_pkg::CMD_SELECT;
    else if (r < 98) c.cmd = CMD_INIT_LO;
    else             c.cmd = CMD_INIT_HI;
    return c;
  endfunction

  // ---------------------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------------------

  initial begin : stimulus
    int                idle_plan [PASS_COUNT];
    int                mn, mx;
    cqss_pkg::cmd_t    c;
    cqss_pkg::result_t none;

    // shadow comes up like the hardware: register defaults, every score at 100
    shadow_cfg = '{cqss_pkg::MIN_CHANNEL_RST, cqss_pkg::MAX_CHANNEL_RST,
                   cqss_pkg::DEFAULT_CHANNEL_RST, cqss_pkg::SCORE_START_RST,
                   cqss_pkg::SCORE_CEILING_RST, cqss_pkg::SUCCESS_STEP_RST,
                   cqss_pkg::FAILURE_STEP_RST};
    shadow_soft_init();
    none = '0;
    // sender idling per random pass: none, heavy, none, light, heavy, light
    idle_plan = '{0, 81, 0, 6, 81, 6};

    // out of reset: all scores equal, current channel 0 holds the tie
    plan_typed(cqss_pkg::CMD_SELECT, 0, 0, 0, 0, 0, 1);
    plan_typed(cqss_pkg::CMD_SUCCESS, 127, 0, 0, 0, 0, 1);
    plan_typed(cqss_pkg::CMD_SELECT, 0, 0, 0, 0, 127, 1);
    plan_typed(cqss_pkg::CMD_SET_CHANNEL, 127, 0, 127, 0, 0, 1);
    plan_typed(cqss_pkg::CMD_SELECT, 0, 0, 127, 0, 127, 1);
    // epoch load and wrap past 255
    plan_typed(cqss_pkg::CMD_SET_EPOCH, 0, 255, 127, 255, 0, 1);
    plan_typed(cqss_pkg::CMD_NEXT_EPOCH, 0, 0, 127, 0, 0, 1);
    plan_cmd(cqss_pkg::CMD_FAILURE, 127, 0);
    plan_cmd(cqss_pkg::CMD_FAILURE, 127, 0);
    plan_cmd(cqss_pkg::CMD_SELECT, 0, 0);
    // both soft init codes; a tie after init goes to the current channel
    plan_typed(CMD_INIT_LO, 0, 0, 0, 0, 0, 1);
    plan_typed(cqss_pkg::CMD_SET_CHANNEL, 64, 0, 64, 0, 0, 1);
    plan_typed(cqss_pkg::CMD_SELECT, 0, 0, 64, 0, 64, 1);
    plan_typed(CMD_INIT_HI, 0, 0, 0, 0, 0, 1);
    // full steps: clamp at zero and at the top of the range
    plan_reg(cqss_pkg::REG_FAILURE_STEP, 1023);
    plan_typed(cqss_pkg::CMD_FAILURE, 3, 0, 0, 0, 0, 1);
    plan_typed(cqss_pkg::CMD_SELECT, 0, 0, 0, 0, 0, 1);
    plan_reg(cqss_pkg::REG_SUCCESS_STEP, 1023);
    plan_reg(cqss_pkg::REG_SCORE_CEILING, 1023);
    plan_cmd(cqss_pkg::CMD_SUCCESS, 9, 0);
    plan_typed(cqss_pkg::CMD_SELECT, 0, 0, 0, 0, 9, 1);
    // narrowed window: both edges rejected, inner edge taken
    plan_reg(cqss_pkg::REG_MIN_CHANNEL, 1);
    plan_reg(cqss_pkg::REG_MAX_CHANNEL, 126);
    plan_typed(cqss_pkg::CMD_SUCCESS, 0, 0, 0, 0, 0, 0);
    plan_typed(cqss_pkg::CMD_FAILURE, 127, 0, 0, 0, 0, 0);
    plan_typed(cqss_pkg::CMD_SET_CHANNEL, 127, 0, 0, 0, 0, 0);
    plan_typed(cqss_pkg::CMD_SET_CHANNEL, 126, 0, 126, 0, 0, 1);
    // empty window: min above max rejects everything
    plan_reg(cqss_pkg::REG_MIN_CHANNEL, 127);
    plan_reg(cqss_pkg::REG_MAX_CHANNEL, 0);
    plan_typed(cqss_pkg::CMD_SET_CHANNEL, 64, 0, 126, 0, 0, 0);
    // start value above the ceiling, pulled down by the next update
    plan_reg(cqss_pkg::REG_MIN_CHANNEL, 0);
    plan_reg(cqss_pkg::REG_MAX_CHANNEL, 127);
    plan_reg(cqss_pkg::REG_DEFAULT_CHANNEL, 0);
    plan_reg(cqss_pkg::REG_SCORE_START, 1023);
    plan_reg(cqss_pkg::REG_SCORE_CEILING, 500);
    plan_reg(cqss_pkg::REG_SUCCESS_STEP, 1);
    plan_typed(CMD_INIT_LO, 0, 0, 0, 0, 0, 1);
    plan_cmd(cqss_pkg::CMD_SUCCESS, 2, 0);
    plan_cmd(cqss_pkg::CMD_FAILURE, 2, 0);
    plan_typed(cqss_pkg::CMD_SELECT, 0, 0, 0, 0, 0, 1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
        // valid stays high across a run of register rows
        if (i == plan.size() - 1 || !plan[i+1].is_reg) cfg_valid_i <= 1'b0;
      end else begin
        send_cmd(plan[i].c, plan[i].typed, plan[i].want);
      end
    end

    // random passes, each under its own register setting
    for (int p = 0; p < PASS_COUNT; p++) begin
      case (p)
        0: load_settings(0, 127, 0, 100, 1000, 1, 10);
        1: load_settings(0, 127, 127, 1023, 1023, 1023, 1023);
        2: load_settings(10, 40, 20, 500, 600, 7, 13);
        3: begin
          mn = $urandom_range(0, 63);
          mx = $urandom_range(mn, 127);
          load_settings(mn, mx, $urandom_range(0, 127), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 60), $urandom_range(0, 200));
        end
        4: load_settings(127, 127, 127, 0, 0, 0, 0);
        default: load_settings($urandom_range(0, 127), $urandom_range(0, 127),
                               $urandom_range(0, 127), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1023));
      endcase
      sender_idle_pct = idle_plan[p];
      // fresh scores and channel from the new start and default values
      c = '0;
      c.cmd = CMD_INIT_LO;
      send_cmd(c, 1'b0, none);
      for (int n = 1; n < ITEMS_PER_PASS; n++) send_cmd(random_cmd(), 1'b0, none);
    end

    drain();
    // a stray strobe after the last one would still show up before the final check
    repeat (CH_COUNT + 4) @(posedge clk_i);
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
